FILE: sv/srw_pkg.sv
// Package for the selective-repeat receive window.
// Holds the transfer structs, the slot entry type and the default parameter values.
// No dependencies.
`default_nettype none

package srw_pkg;

  localparam int DEF_WINDOW_FRAMES   = 16;
  localparam int DEF_MAX_FRAME_BYTES = 1024;

  localparam int SEQ_W = 32;
  localparam int LEN_W = 11;

  // Register index codes (byte address bit 2 selects the register).
  localparam logic REG_TOTAL_FRAMES = 1'b0;

  typedef struct packed {
    logic [SEQ_W-1:0] frame_number;
    logic [31:0]      payload_handle;
    logic [LEN_W-1:0] payload_length;
  } frame_t;

  typedef struct packed {
    logic [SEQ_W-1:0] out_sequence;
    logic [31:0]      out_payload;
    logic [LEN_W-1:0] out_length;
    logic             last;
    logic             stream_done;
  } result_t;

  typedef struct packed {
    logic [31:0]      payload;
    logic [LEN_W-1:0] length;
  } slot_entry_t;

endpackage

`default_nettype wire

FILE: sv/srw_slot_mem.sv
// Slot store of the receive window: one payload descriptor and length per slot.
// One write port and one registered read port. Depends on srw_pkg.
`default_nettype none

module srw_slot_mem
  import srw_pkg::*;
#(
  parameter int DEPTH  = 2 * DEF_WINDOW_FRAMES,
  parameter int ADDR_W = $clog2(2 * DEF_WINDOW_FRAMES)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  slot_entry_t       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output slot_entry_t       rd_data
);

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/selective_repeat_receive_window.sv
// Selective-repeat receive window, top level.
// Sequencer, slot bitmap, head counter and configuration port; uses srw_pkg and srw_slot_mem.
`default_nettype none

// A user should know this first: every frame transfer is taken in the idle state and then
// checked against the delivery head by one shared 33-bit subtractor, which yields both the
// stale test (borrow) and the distance used for the window test and the slot index. A frame
// that is stale, at or beyond head + 2*WINDOW_FRAMES, or already marked is dropped silently.
// Otherwise its descriptor and saturated length go into the slot memory and its bit is set in
// the bitmap. The run of marked slots starting at the head is then delivered in order, one
// result transfer at a time; the final result of the run carries last, and stream_done shows
// that the head after that delivery equals total_frames. A frame passes accept and check; each
// delivered result adds a slot memory read, a result load and a result transfer, which waits
// while the output side is not ready; the registered memory read port makes the read a step
// of its own. No new frame is taken until the whole run has been delivered. total_frames sits
// at byte address 0 of the APB port; the user must write it only while the block is idle,
// which the block itself does not enforce. The slot memory needs no clearing pass: an entry
// is read only after its bitmap bit has been set, and the bitmap is cleared by reset.

module selective_repeat_receive_window
  import srw_pkg::*;
#(
  parameter int WINDOW_FRAMES   = DEF_WINDOW_FRAMES,
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // Received frames.
  input  logic        frame_valid,
  output logic        frame_ready,
  input  frame_t      frame,
  // Results delivered in order.
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  // APB configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOT_COUNT = 2 * WINDOW_FRAMES;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_BYTES);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_SEND  = 3'd4;

  logic [2:0]            state, state_next;
  logic [SEQ_W-1:0]      total_frames;
  logic [SEQ_W-1:0]      head_sequence;
  logic [SLOT_W-1:0]     head_slot;
  logic [SLOT_COUNT-1:0] arrived_map, arrived_map_next;

  // Captured frame (payload registers, no reset needed).
  logic [SEQ_W-1:0]      frame_number;
  slot_entry_t           frame_entry;

  // Configuration port: the register is written on the access phase of a write transfer.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOTAL_FRAMES) ? total_frames : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TOTAL_FRAMES)) begin
      total_frames <= pwdata;
    end
  end

  // The shared subtractor: the borrow flags a stale frame, the difference is the distance.
  logic [SEQ_W:0]    distance;
  logic              stale;
  logic              too_far;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] frame_slot;
  logic              duplicate;
  logic              keep_frame;

  assign distance = {1'b0, frame_number} - {1'b0, head_sequence};
  assign stale    = distance[SEQ_W];
  assign too_far  = distance[SEQ_W-1:0] >= SEQ_W'(SLOT_COUNT);

  // Slot of the frame: head slot plus distance, wrapped once (distance is below SLOT_COUNT).
  assign slot_sum   = {1'b0, head_slot} + {1'b0, distance[SLOT_W-1:0]};
  assign frame_slot = (slot_sum >= (SLOT_W + 1)'(SLOT_COUNT)) ?
                      SLOT_W'(slot_sum - (SLOT_W + 1)'(SLOT_COUNT)) : slot_sum[SLOT_W-1:0];
  assign duplicate  = arrived_map[frame_slot];
  assign keep_frame = !stale && !too_far && !duplicate;

  // Delivery bookkeeping for the head slot.
  logic [SLOT_W-1:0]     next_slot;
  logic [SEQ_W-1:0]      head_plus;
  logic [SLOT_COUNT-1:0] map_cleared;

  assign next_slot = (head_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : head_slot + SLOT_W'(1);
  assign head_plus = head_sequence + SEQ_W'(1);

  always_comb begin
    map_cleared            = arrived_map;
    map_cleared[head_slot] = 1'b0;
  end

  // Slot memory.
  logic        mem_wr_en;
  slot_entry_t mem_rd_data;

  assign mem_wr_en = (state == ST_CHECK) && keep_frame;

  srw_slot_mem #(
    .DEPTH  (SLOT_COUNT),
    .ADDR_W (SLOT_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (frame_slot),
    .wr_data (frame_entry),
    .rd_addr (head_slot),
    .rd_data (mem_rd_data)
  );

  // Sequencer.
  always_comb begin
    state_next       = state;
    arrived_map_next = arrived_map;
    case (state)
      ST_IDLE: begin
        if (frame_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (keep_frame) begin
          arrived_map_next[frame_slot] = 1'b1;
          // Deliver only if the head slot is now marked.
          state_next = arrived_map_next[head_slot] ? ST_READ : ST_IDLE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        arrived_map_next = map_cleared;
        state_next       = ST_SEND;
      end
      ST_SEND: begin
        if (result_ready) begin
          state_next = result.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign frame_ready  = (state == ST_IDLE);
  assign result_valid = (state == ST_SEND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      arrived_map   <= '0;
      head_sequence <= '0;
      head_slot     <= '0;
    end else begin
      state       <= state_next;
      arrived_map <= arrived_map_next;
      if (state == ST_LOAD) begin
        head_sequence <= head_plus;
        head_slot     <= next_slot;
      end
    end
  end

  // Capture the frame on its transfer; the length saturates at the largest frame size.
  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      frame_number        <= frame.frame_number;
      frame_entry.payload <= frame.payload_handle;
      if ({5'd0, frame.payload_length} > MAX_LEN) begin
        frame_entry.length <= MAX_LEN[LEN_W-1:0];
      end else begin
        frame_entry.length <= frame.payload_length;
      end
    end
  end

  // Result register. The run ends when the slot after the head is not marked.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      result.out_sequence <= head_sequence;
      result.out_payload  <= mem_rd_data.payload;
      result.out_length   <= mem_rd_data.length;
      result.last         <= !map_cleared[next_slot];
      result.stream_done  <= (head_plus == total_frames);
    end
  end

endmodule

`default_nettype wire
